>>> src/rlu_pkg.sv
// Shared types and constants for the run-length decoder.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package rlu_pkg;

    // Bits of the header size that are kept (8..32).
    localparam int SIZE_BITS = 32;
    localparam int HDR_W     = 32;
    localparam int STATUS_W  = 3;

    localparam logic [HDR_W-1:0] SIZE_MASK = HDR_W'((64'd1 << SIZE_BITS) - 64'd1);
    localparam logic [7:0]       LONG_CTRL = 8'h80;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_TOKEN,
        PH_REP_VAL,
        PH_LIT_VAL,
        PH_LONG_VAL,
        PH_LONG_LO,
        PH_LONG_HI,
        PH_LIT_REST,
        PH_TERM,
        PH_DISCARD
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_RUN      = 3'd0,
        ST_DONE     = 3'd1,
        ST_ZERO_LIT = 3'd2,
        ST_OVERRUN  = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_BADTERM  = 3'd5
    } status_t;

    typedef struct packed {
        logic             emit;
        logic [7:0]       out_value;
        logic [15:0]      run_length;
        status_t          status;
        logic [HDR_W-1:0] total_size;
        logic             stream_end;
    } result_t;

endpackage

>>> src/rlu_if.sv
// Valid/ready channels: compressed byte requests in, decoded run requests out.
// Depends on rlu_pkg.
`timescale 1ns / 1ps

interface rlu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface rlu_out_if
    import rlu_pkg::*;
    ;
    logic                valid;
    logic                ready;
    logic [7:0]          out_value;
    logic [15:0]         run_length;
    logic [STATUS_W-1:0] status;
    logic [HDR_W-1:0]    total_size;
    logic                stream_end;

    modport source (output valid, output out_value, output run_length, output status,
                    output total_size, output stream_end, input ready);
    modport sink   (input valid, input out_value, input run_length, input status,
                    input total_size, input stream_end, output ready);
endinterface

>>> src/rlu_decode_core.sv
// Decoder state and per-byte decode logic: one byte per step strobe.
// Depends on rlu_pkg.
`timescale 1ns / 1ps

module rlu_decode_core
    import rlu_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       step,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    output result_t    res
);

    phase_t           phase_reg, phase_next;
    logic [1:0]       hdr_idx_reg, hdr_idx_next;
    logic [HDR_W-1:0] expected_reg, expected_next;
    // Remaining = expected size minus what has been produced so far.
    logic [HDR_W-1:0] remaining_reg, remaining_next;
    logic [15:0]      pending_reg, pending_next;
    logic [7:0]       held_reg, held_next;

    logic [15:0]      long_len;
    logic [15:0]      run_len;
    logic             run_over;
    logic             lit_over;
    logic [HDR_W-1:0] rem_after_run;
    logic [HDR_W-1:0] rem_dec;
    logic [15:0]      pend_dec;
    logic [HDR_W-1:0] hdr_full;
    logic [HDR_W-1:0] hdr_kept;

    assign long_len      = {data_byte, pending_reg[7:0]};
    assign run_len       = (phase_reg == PH_LONG_HI) ? long_len : pending_reg;
    assign run_over      = HDR_W'(run_len) > remaining_reg;
    assign lit_over      = HDR_W'(pending_reg) > remaining_reg;
    assign rem_after_run = remaining_reg - HDR_W'(run_len);
    assign rem_dec       = remaining_reg - HDR_W'(1);
    assign pend_dec      = pending_reg - 16'd1;
    assign hdr_full      = expected_reg | (HDR_W'(data_byte) << {hdr_idx_reg, 3'b000});
    assign hdr_kept      = hdr_full & SIZE_MASK;

    // Result for the byte on the inputs
    always_comb
    begin
        res = '0;
        res.status = ST_RUN;
        case (phase_reg)
            PH_HEADER, PH_TOKEN, PH_LONG_VAL, PH_LONG_LO, PH_LIT_REST:
            begin
                if (last_byte)
                begin
                    res.emit   = 1'b1;
                    res.status = ST_TRUNC;
                end
                else if (phase_reg == PH_LIT_REST)
                begin
                    res.emit       = 1'b1;
                    res.out_value  = data_byte;
                    res.run_length = 16'd1;
                end
            end
            PH_REP_VAL, PH_LONG_HI:
            begin
                if (run_over)
                begin
                    res.emit   = 1'b1;
                    res.status = ST_OVERRUN;
                end
                else if (last_byte)
                begin
                    res.emit   = 1'b1;
                    res.status = ST_TRUNC;
                end
                else if (run_len != 16'd0)
                begin
                    res.emit       = 1'b1;
                    res.out_value  = (phase_reg == PH_REP_VAL) ? data_byte : held_reg;
                    res.run_length = run_len;
                end
            end
            PH_LIT_VAL:
            begin
                res.emit = 1'b1;
                if (pending_reg == 16'd0)
                    res.status = ST_ZERO_LIT;
                else if (lit_over)
                    res.status = ST_OVERRUN;
                else if (last_byte)
                    res.status = ST_TRUNC;
                else
                begin
                    res.out_value  = data_byte;
                    res.run_length = 16'd1;
                end
            end
            PH_TERM:
            begin
                res.emit = 1'b1;
                if (data_byte != 8'd0 || !last_byte)
                    res.status = ST_BADTERM;
                else
                begin
                    res.status     = ST_DONE;
                    res.total_size = expected_reg;
                end
            end
            default:
            begin
                res.emit = 1'b0;
            end
        endcase
        res.stream_end = res.emit && (res.status != ST_RUN);
    end

    // Next state
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        expected_next  = expected_reg;
        remaining_next = remaining_reg;
        pending_next   = pending_reg;
        held_next      = held_reg;
        if (res.stream_end && (last_byte || res.status == ST_DONE)
            || phase_reg == PH_DISCARD && last_byte)
        begin
            phase_next     = PH_HEADER;
            hdr_idx_next   = 2'd0;
            expected_next  = '0;
            remaining_next = '0;
            pending_next   = '0;
            held_next      = '0;
        end
        else if (res.stream_end)
        begin
            phase_next = PH_DISCARD;
        end
        else
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    hdr_idx_next = hdr_idx_reg + 2'd1;
                    if (hdr_idx_reg == 2'd3)
                    begin
                        expected_next  = hdr_kept;
                        remaining_next = hdr_kept;
                        phase_next     = (hdr_kept == '0) ? PH_TERM : PH_TOKEN;
                    end
                    else
                        expected_next = hdr_full;
                end
                PH_TOKEN:
                begin
                    if (data_byte > LONG_CTRL)
                    begin
                        pending_next = {9'd0, data_byte[6:0]};
                        phase_next   = PH_REP_VAL;
                    end
                    else if (data_byte == LONG_CTRL)
                    begin
                        pending_next = {8'd0, data_byte};
                        phase_next   = PH_LONG_VAL;
                    end
                    else
                    begin
                        pending_next = {8'd0, data_byte};
                        phase_next   = PH_LIT_VAL;
                    end
                end
                PH_REP_VAL, PH_LONG_HI:
                begin
                    pending_next   = run_len;
                    remaining_next = rem_after_run;
                    phase_next     = (rem_after_run == '0) ? PH_TERM : PH_TOKEN;
                end
                PH_LIT_VAL, PH_LIT_REST:
                begin
                    remaining_next = rem_dec;
                    pending_next   = pend_dec;
                    if (pend_dec != 16'd0)
                        phase_next = PH_LIT_REST;
                    else
                        phase_next = (rem_dec == '0) ? PH_TERM : PH_TOKEN;
                end
                PH_LONG_VAL:
                begin
                    held_next  = data_byte;
                    phase_next = PH_LONG_LO;
                end
                PH_LONG_LO:
                begin
                    pending_next = {8'd0, data_byte};
                    phase_next   = PH_LONG_HI;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= 2'd0;
            expected_reg  <= '0;
            remaining_reg <= '0;
            pending_reg   <= '0;
            held_reg      <= '0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            expected_reg  <= expected_next;
            remaining_reg <= remaining_next;
            pending_reg   <= pending_next;
            held_reg      <= held_next;
        end
    end

endmodule

>>> src/rlu_run_length_decoder.sv
// Byte requests are held in the input register, runs in the result register.
// Throughput: one compressed byte per cycle unless a run meets a stalled output.
// The core steps once per byte; a byte with no run moves on even in a stall.
// Reset (rst_n low, asynchronous) empties both registers and returns to the header.
// Top level: input register, decode core, result register. Depends on rlu_pkg,
// rlu_if and rlu_decode_core.
`timescale 1ns / 1ps

module rlu_run_length_decoder
    import rlu_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    rlu_in_if.sink   bytes_ch,
    rlu_out_if.source runs_ch
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;

    result_t    res;
    logic       advance;
    logic       take;

    rlu_decode_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .data_byte (in_data_reg),
        .last_byte (in_last_reg),
        .res       (res)
    );

    assign advance        = in_valid_reg && (!res.emit || !out_valid_reg || runs_ch.ready);
    assign bytes_ch.ready = !in_valid_reg || advance;
    assign take           = bytes_ch.valid && bytes_ch.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && res.emit)
            out_valid_next = 1'b1;
        else if (runs_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            in_data_reg <= bytes_ch.data_byte;
            in_last_reg <= bytes_ch.last_byte;
        end
        if (advance && res.emit)
            out_res_reg <= res;
    end

    assign runs_ch.valid      = out_valid_reg;
    assign runs_ch.out_value  = out_res_reg.out_value;
    assign runs_ch.run_length = out_res_reg.run_length;
    assign runs_ch.status     = out_res_reg.status;
    assign runs_ch.total_size = out_res_reg.total_size;
    assign runs_ch.stream_end = out_res_reg.stream_end;

endmodule

>>> src/rlu_checker.sv
// Port-level checks on the decoder's run requests, bound to the top level.
// Depends on rlu_pkg and rlu_run_length_decoder.
`timescale 1ns / 1ps

module rlu_checker
    import rlu_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input logic [7:0]          out_value,
    input logic [15:0]         run_length,
    input logic [STATUS_W-1:0] status,
    input logic [HDR_W-1:0]    total_size,
    input logic                stream_end
);

    // A stalled request holds its payload
    ap_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(run_length)
            && $stable(out_value) && $stable(stream_end))
        else $error("run request changed while stalled");

    // A run never has zero length and never ends the stream
    ap_run_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_RUN |-> run_length != 16'd0 && !stream_end
            && total_size == '0)
        else $error("malformed run request");

    // Every non-run result ends the stream and carries no run
    ap_end_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_RUN |-> stream_end && out_value == 8'd0
            && run_length == 16'd0)
        else $error("malformed end request");

    // Size is reported only with done
    ap_size_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_DONE |-> total_size == '0)
        else $error("total size outside done");

endmodule

bind rlu_run_length_decoder rlu_checker u_rlu_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (runs_ch.valid),
    .out_ready  (runs_ch.ready),
    .out_value  (runs_ch.out_value),
    .run_length (runs_ch.run_length),
    .status     (runs_ch.status),
    .total_size (runs_ch.total_size),
    .stream_end (runs_ch.stream_end)
);
